### rtl/core/sbpv_pkg.sv
// ----------------------------------------------------------------------------
// sbpv_pkg
// Shared types, constants and helpers for the sphere/box push-back pipeline.
// ----------------------------------------------------------------------------
package sbpv_pkg;

    localparam int COORD_WIDTH    = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int EPS_W          = 16;
    localparam int AXES           = 3;
    localparam int MAG_W          = COORD_WIDTH - 1 + EPS_W;

    localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(7);

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] box_x;
        logic signed [COORD_WIDTH-1:0] box_y;
        logic signed [COORD_WIDTH-1:0] box_z;
        logic [COORD_WIDTH-2:0]        box_size_x;
        logic [COORD_WIDTH-2:0]        box_size_y;
        logic [COORD_WIDTH-2:0]        box_size_z;
        logic signed [COORD_WIDTH-1:0] sphere_x;
        logic signed [COORD_WIDTH-1:0] sphere_y;
        logic signed [COORD_WIDTH-1:0] sphere_z;
        logic [COORD_WIDTH-2:0]        sphere_radius;
    } t_in;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] push_x;
        logic signed [COORD_WIDTH-1:0] push_y;
        logic signed [COORD_WIDTH-1:0] push_z;
        logic                          penetrating;
    } t_out;

    // travels alongside the square-root chain
    typedef struct packed {
        logic                               tiny;
        logic                               reach;
        logic [AXES-1:0]                    neg;
        logic [AXES-1:0][COORD_WIDTH-2:0]   ad;
        logic [COORD_WIDTH-2:0]             radius;
        logic                               dneg;
        logic [MAG_W-1:0]                   dmag;
    } t_sq_side;

    // travels alongside the divider chain
    typedef struct packed {
        logic             degen;
        logic             do_div;
        logic [AXES-1:0]  neg;
        logic             dneg;
        logic [MAG_W-1:0] dmag;
    } t_dv_side;

    // signed saturation of a magnitude with a separate sign
    function automatic logic [COORD_WIDTH-1:0] sat_mag(input logic [MAG_W-1:0] m,
                                                      input logic neg);
        logic [MAG_W-1:0] lim;
        lim = {{(MAG_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
        if (!neg) begin
            return (m > lim) ? {1'b0, {(COORD_WIDTH-1){1'b1}}} : m[COORD_WIDTH-1:0];
        end else if (m > lim) begin
            return {1'b1, {(COORD_WIDTH-1){1'b0}}};
        end else begin
            return -m[COORD_WIDTH-1:0];
        end
    endfunction

endpackage

### rtl/core/sphere_box_pushback_vector.sv
// ----------------------------------------------------------------------------
// sphere_box_pushback_vector
// Push-back vector of a sphere out of an axis-aligned box, signed fixed point.
// ----------------------------------------------------------------------------
// Input channel i_valid/o_stall carries one box/sphere query per transaction;
// output channel o_valid/i_stall carries one push vector per query, in order.
// A query is taken on every cycle in which o_stall is low: throughput is one
// transaction per clock. The pipeline holds the square-root chain (one root
// bit per cell), the divider chain (one quotient bit per cell) and the clamp,
// multiply and output stages.
// The result sits in an output register; a one-deep skid register behind it
// catches the next result when the receiver stalls, and only once the skid is
// full does o_stall rise and the whole pipeline hold.
// i_cfg_we writes the epsilon threshold; write it only while no query is in
// flight. Synchronous reset (i_rst_n low) empties the pipeline and sets
// epsilon to 7; no pass over any storage follows reset.
// ----------------------------------------------------------------------------
module sphere_box_pushback_vector import sbpv_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  t_in              i_data,
    output logic             o_valid,
    input  logic             i_stall,
    output t_out             o_data,
    input  logic             i_cfg_we,
    input  logic [EPS_W-1:0] i_cfg_wdata
);

    localparam int CW    = COORD_WIDTH;
    localparam int SQ_SW = $bits(t_sq_side);
    localparam int DV_SW = $bits(t_dv_side);

    logic             en;
    logic [EPS_W-1:0] r_eps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= EPS_RESET;
        end else if (i_cfg_we) begin
            r_eps <= i_cfg_wdata;
        end
    end

    // ---------------- stage 1: box bounds and centre offset ----------------
    logic signed [CW-1:0] c  [AXES];
    logic [CW-2:0]        sz [AXES];
    logic signed [CW-1:0] s  [AXES];

    always_comb begin
        c[0]  = i_data.box_x;      c[1]  = i_data.box_y;      c[2]  = i_data.box_z;
        sz[0] = i_data.box_size_x; sz[1] = i_data.box_size_y; sz[2] = i_data.box_size_z;
        s[0]  = i_data.sphere_x;   s[1]  = i_data.sphere_y;   s[2]  = i_data.sphere_z;
    end

    logic                r1_valid;
    logic signed [CW:0]  r1_lo [AXES];
    logic signed [CW:0]  r1_hi [AXES];
    logic signed [CW:0]  r1_s  [AXES];
    logic signed [CW:0]  r1_e;
    logic [CW-2:0]       r1_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < AXES; k++) begin
                r1_lo[k] <= $signed({c[k][CW-1], c[k]}) - $signed({3'b000, sz[k][CW-2:1]});
                r1_hi[k] <= $signed({c[k][CW-1], c[k]}) + $signed({3'b000, sz[k][CW-2:1]});
                r1_s[k]  <= $signed({s[k][CW-1], s[k]});
            end
            r1_e      <= $signed({s[0][CW-1], s[0]}) - $signed({c[0][CW-1], c[0]});
            r1_radius <= i_data.sphere_radius;
        end
    end

    // ---------------- stage 2: clamp, offsets, flags, degenerate push ------
    logic signed [CW:0] nr [AXES];
    logic signed [CW:0] d  [AXES];
    logic [CW:0]        ad [AXES];
    logic [CW:0]        ae;
    logic [MAG_W-1:0]   dprod;
    t_sq_side           n2_side;

    always_comb begin
        n2_side        = '0;
        n2_side.tiny   = 1'b1;
        n2_side.reach  = 1'b1;
        for (int k = 0; k < AXES; k++) begin
            if (r1_s[k] < r1_lo[k]) begin
                nr[k] = r1_lo[k];
            end else if (r1_s[k] > r1_hi[k]) begin
                nr[k] = r1_hi[k];
            end else begin
                nr[k] = r1_s[k];
            end
            d[k]  = r1_s[k] - nr[k];
            ad[k] = d[k][CW] ? (CW+1)'(-d[k]) : (CW+1)'(d[k]);
            if (ad[k] > {{(CW+1-EPS_W){1'b0}}, r_eps}) begin
                n2_side.tiny = 1'b0;
            end
            if (ad[k] >= {2'b00, r1_radius}) begin
                n2_side.reach = 1'b0;
            end
            n2_side.neg[k] = d[k][CW];
            n2_side.ad[k]  = ad[k][CW-2:0];
        end
        ae    = r1_e[CW] ? (CW+1)'(-r1_e) : (CW+1)'(r1_e);
        dprod = MAG_W'(r1_radius) * MAG_W'(ae[EPS_W-1:0]);
        n2_side.radius = r1_radius;
        n2_side.dneg   = r1_e[CW];
        if (ae < {{(CW+1-EPS_W){1'b0}}, r_eps}) begin
            n2_side.dmag = dprod >> FRAC_BITS;
        end else if (r1_e != '0) begin
            n2_side.dmag = MAG_W'(r1_radius);
        end else begin
            n2_side.dmag = '0;
        end
    end

    logic     r2_valid;
    t_sq_side r2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_side <= n2_side;
        end
    end

    // ---------------- stage 3: squares; stage 4: sum ------------------------
    logic                  r3_valid;
    logic [2*CW-3:0]       r3_sq [AXES];
    t_sq_side              r3_side;
    logic                  r4_valid;
    logic [2*CW-1:0]       r4_sum;
    t_sq_side              r4_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (en) begin
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < AXES; k++) begin
                r3_sq[k] <= (2*CW-2)'(r2_side.ad[k]) * (2*CW-2)'(r2_side.ad[k]);
            end
            r3_side <= r2_side;
            r4_sum  <= (2*CW)'(r3_sq[0]) + (2*CW)'(r3_sq[1]) + (2*CW)'(r3_sq[2]);
            r4_side <= r3_side;
        end
    end

    // ---------------- square-root chain ------------------------------------
    logic             sq_valid [CW+1];
    logic [2*CW-1:0]  sq_rem   [CW+1];
    logic [CW-1:0]    sq_root  [CW+1];
    logic [SQ_SW-1:0] sq_side  [CW+1];

    assign sq_valid[0] = r4_valid;
    assign sq_rem[0]   = r4_sum;
    assign sq_root[0]  = '0;
    assign sq_side[0]  = r4_side;

    for (genvar g = 0; g < CW; g++) begin : g_sqrt
        sbpv_sqrt_cell #(
            .W      (CW),
            .STEP   (CW - 1 - g),
            .SIDE_W (SQ_SW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (sq_valid[g]),
            .i_rem   (sq_rem[g]),
            .i_root  (sq_root[g]),
            .i_side  (sq_side[g]),
            .o_valid (sq_valid[g+1]),
            .o_rem   (sq_rem[g+1]),
            .o_root  (sq_root[g+1]),
            .o_side  (sq_side[g+1])
        );
    end

    // ---------------- stage 5: case decision, overlap ------------------------
    t_sq_side       sq_out;
    logic [CW-1:0]  sq_dist;
    t_dv_side       n5_side;

    always_comb begin
        sq_out         = sq_side[CW];
        sq_dist        = sq_root[CW];
        n5_side.degen  = sq_out.tiny && (sq_dist <= {{(CW-EPS_W){1'b0}}, r_eps});
        n5_side.do_div = !n5_side.degen && sq_out.reach && (sq_dist != '0)
                         && (sq_dist < {1'b0, sq_out.radius});
        n5_side.neg    = sq_out.neg;
        n5_side.dneg   = sq_out.dneg;
        n5_side.dmag   = sq_out.dmag;
    end

    logic                       r5_valid;
    t_dv_side                   r5_side;
    logic [CW-2:0]              r5_overlap;
    logic [CW-2:0]              r5_dv;
    logic [AXES-1:0][CW-2:0]    r5_ad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (en) begin
            r5_valid <= sq_valid[CW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_side    <= n5_side;
            r5_overlap <= sq_out.radius - sq_dist[CW-2:0];
            r5_dv      <= sq_dist[CW-2:0];
            r5_ad      <= sq_out.ad;
        end
    end

    // ---------------- stage 6: offset times overlap ------------------------
    logic                       r6_valid;
    t_dv_side                   r6_side;
    logic [AXES-1:0][2*CW-3:0]  r6_num;
    logic [CW-2:0]              r6_dv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_valid <= 1'b0;
        end else if (en) begin
            r6_valid <= r5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < AXES; k++) begin
                r6_num[k] <= (2*CW-2)'(r5_ad[k]) * (2*CW-2)'(r5_overlap);
            end
            r6_side <= r5_side;
            r6_dv   <= r5_dv;
        end
    end

    // ---------------- divider chain ----------------------------------------
    logic                       dv_valid [CW];
    logic [AXES-1:0][2*CW-3:0]  dv_rem   [CW];
    logic [AXES-1:0][CW-2:0]    dv_quo   [CW];
    logic [CW-2:0]              dv_dv    [CW];
    logic [DV_SW-1:0]           dv_side  [CW];

    assign dv_valid[0] = r6_valid;
    assign dv_rem[0]   = r6_num;
    assign dv_quo[0]   = '0;
    assign dv_dv[0]    = r6_dv;
    assign dv_side[0]  = r6_side;

    for (genvar g = 0; g < CW - 1; g++) begin : g_div
        sbpv_div_cell #(
            .W      (CW),
            .STEP   (CW - 2 - g),
            .SIDE_W (DV_SW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (dv_valid[g]),
            .i_rem   (dv_rem[g]),
            .i_quo   (dv_quo[g]),
            .i_dv    (dv_dv[g]),
            .i_side  (dv_side[g]),
            .o_valid (dv_valid[g+1]),
            .o_rem   (dv_rem[g+1]),
            .o_quo   (dv_quo[g+1]),
            .o_dv    (dv_dv[g+1]),
            .o_side  (dv_side[g+1])
        );
    end

    // ---------------- result select and saturation -------------------------
    t_dv_side                 tl_side;
    logic [AXES-1:0][CW-1:0]  push;
    t_out                     tl_data;

    always_comb begin
        tl_side = dv_side[CW-1];
        for (int k = 0; k < AXES; k++) begin
            if (tl_side.degen) begin
                push[k] = (k == 0) ? sat_mag(tl_side.dmag, tl_side.dneg) : '0;
            end else if (tl_side.do_div) begin
                push[k] = sat_mag(MAG_W'(dv_quo[CW-1][k]), tl_side.neg[k]);
            end else begin
                push[k] = '0;
            end
        end
        tl_data.push_x      = push[0];
        tl_data.push_y      = push[1];
        tl_data.push_z      = push[2];
        tl_data.penetrating = (push[0] != '0) || (push[1] != '0) || (push[2] != '0);
    end

    // ---------------- output register and skid -----------------------------
    logic r_out_valid;
    t_out r_out;
    logic r_skid_valid;
    t_out r_skid;
    logic out_free;

    assign en       = !r_skid_valid;
    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_free) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (out_free) begin
            r_out_valid <= dv_valid[CW-1];
        end else if (dv_valid[CW-1]) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_free) begin
                r_out <= r_skid;
            end
        end else if (out_free) begin
            r_out <= tl_data;
        end else begin
            r_skid <= tl_data;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;
    assign o_stall = r_skid_valid;

endmodule

### rtl/core/sbpv_sqrt_cell.sv
// ----------------------------------------------------------------------------
// sbpv_sqrt_cell
// One restoring square-root stage: one root bit per cycle while i_en is high.
// ----------------------------------------------------------------------------
module sbpv_sqrt_cell import sbpv_pkg::*; #(
    parameter int W      = COORD_WIDTH,
    parameter int STEP   = 0,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [2*W-1:0]    i_rem,
    input  logic [W-1:0]      i_root,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [2*W-1:0]    o_rem,
    output logic [W-1:0]      o_root,
    output logic [SIDE_W-1:0] o_side
);

    localparam int W2 = 2 * W;

    logic [W2-1:0]     trial;
    logic              take;
    logic              r_valid;
    logic [W2-1:0]     r_rem;
    logic [W-1:0]      r_root;
    logic [SIDE_W-1:0] r_side;

    // (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b); root bits at and below b are clear
    assign trial = ({{W{1'b0}}, i_root} << (STEP + 1)) | (W2'(1) << (2 * STEP));
    assign take  = (i_rem >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= take ? (i_rem - trial) : i_rem;
            r_root <= take ? (i_root | (W'(1) << STEP)) : i_root;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_side  = r_side;

endmodule

### rtl/core/sbpv_div_cell.sv
// ----------------------------------------------------------------------------
// sbpv_div_cell
// One stage of the three-lane restoring divider: one quotient bit per lane.
// ----------------------------------------------------------------------------
module sbpv_div_cell import sbpv_pkg::*; #(
    parameter int W      = COORD_WIDTH,
    parameter int STEP   = 0,
    parameter int SIDE_W = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [AXES-1:0][2*W-3:0]    i_rem,
    input  logic [AXES-1:0][W-2:0]      i_quo,
    input  logic [W-2:0]                i_dv,
    input  logic [SIDE_W-1:0]           i_side,
    output logic                        o_valid,
    output logic [AXES-1:0][2*W-3:0]    o_rem,
    output logic [AXES-1:0][W-2:0]      o_quo,
    output logic [W-2:0]                o_dv,
    output logic [SIDE_W-1:0]           o_side
);

    localparam int RW = 2 * W - 2;

    logic [RW-1:0]                 trial;
    logic [AXES-1:0][RW-1:0]       n_rem;
    logic [AXES-1:0][W-2:0]        n_quo;
    logic                          r_valid;
    logic [AXES-1:0][RW-1:0]       r_rem;
    logic [AXES-1:0][W-2:0]        r_quo;
    logic [W-2:0]                  r_dv;
    logic [SIDE_W-1:0]             r_side;

    assign trial = RW'(i_dv) << STEP;

    always_comb begin
        for (int k = 0; k < AXES; k++) begin
            if (i_rem[k] >= trial) begin
                n_rem[k] = i_rem[k] - trial;
                n_quo[k] = i_quo[k] | ((W-1)'(1) << STEP);
            end else begin
                n_rem[k] = i_rem[k];
                n_quo[k] = i_quo[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_quo  <= n_quo;
            r_dv   <= i_dv;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;
    assign o_dv    = r_dv;
    assign o_side  = r_side;

endmodule

### bench/tb_sphere_box_pushback_vector.sv
// ----------------------------------------------------------------------------
// tb_sphere_box_pushback_vector
// Self-checking bench for the sphere/box push-back pipeline: a directed table
// of queries, then random geometry under bursty input and a stalling receiver,
// over several epsilon settings. Every result is checked against its table entry or a predictor.
// ----------------------------------------------------------------------------
module tb_sphere_box_pushback_vector;
    import sbpv_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  FRAC      = 16;
    localparam int  CYCLE_CAP = 400000;
    localparam int  DRAIN     = 80;
    localparam int  N_RAND    = 265;
    localparam int  N_PHASE   = 5;
    localparam int  ONE       = 1 << FRAC;

    typedef struct {
        t_in  query;
        bit   typed;
        t_out push;
    } t_row;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_valid     = 1'b0;
    logic             o_stall;
    t_in              i_data      = '0;
    logic             o_valid;
    logic             i_stall     = 1'b0;
    t_out             o_data;
    logic             i_cfg_we    = 1'b0;
    logic [EPS_W-1:0] i_cfg_wdata = '0;

    logic [EPS_W-1:0] eps_now = EPS_RESET;
    t_out             push_q[$];
    int               mismatches = 0;
    int               cycles = 0;

    sphere_box_pushback_vector u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver: runs of stalling and of free flow, sometimes long free stretches
    int stall_run = 0;
    bit stall_mode = 1'b0;
    always @(posedge i_clk) begin
        if (stall_run == 0) begin
            stall_mode = ($urandom_range(0, 2) == 0);
            stall_run  = stall_mode ? $urandom_range(1, 6) : $urandom_range(1, 40);
        end
        stall_run--;
        i_stall <= stall_mode;
    end

    function automatic t_out predict_push(t_in q, logic [EPS_W-1:0] eps);
        longint      cen[3], ctr, half, lo, hi, near, e;
        longint      dv[3], pv[3];
        logic [63:0] ad[3], siz[3], sph[3];
        logic [63:0] rad, ae;
        logic [127:0] sum, root, cand, ov;
        bit          tiny, reach;
        t_out        r;
        cen[0] = q.box_x;     cen[1] = q.box_y;     cen[2] = q.box_z;
        siz[0] = q.box_size_x; siz[1] = q.box_size_y; siz[2] = q.box_size_z;
        sph[0] = 64'(q.sphere_x); sph[1] = 64'(q.sphere_y); sph[2] = 64'(q.sphere_z);
        rad   = 64'(q.sphere_radius);
        tiny  = 1'b1;
        reach = 1'b1;
        pv    = '{0, 0, 0};
        for (int i = 0; i < 3; i++) begin
            ctr  = cen[i];
            half = longint'(siz[i] >> 1);
            lo   = ctr - half;
            hi   = ctr + half;
            e    = longint'($signed(sph[i][31:0]));
            near = (e < lo) ? lo : ((e > hi) ? hi : e);
            dv[i] = e - near;
            ad[i] = (dv[i] < 0) ? 64'(-dv[i]) : 64'(dv[i]);
            if (ad[i] > eps) tiny = 1'b0;
            if (ad[i] >= rad) reach = 1'b0;
        end
        sum = 128'(ad[0]) * ad[0] + 128'(ad[1]) * ad[1] + 128'(ad[2]) * ad[2];
        root = '0;
        for (int b = 63; b >= 0; b--) begin
            cand = root | (128'(1) << b);
            if (cand * cand <= sum) root = cand;
        end
        if (tiny && root <= eps) begin
            // nearly touching the centre: push along x only
            e  = longint'(q.sphere_x) - longint'(q.box_x);
            ae = (e < 0) ? 64'(-e) : 64'(e);
            if (ae < eps) pv[0] = longint'((rad * ae) >> FRAC);
            else if (e != 0) pv[0] = longint'(rad);
            if (e < 0) pv[0] = -pv[0];
        end else if (reach && root != 0 && root < rad) begin
            ov = 128'(rad) - root;
            for (int i = 0; i < 3; i++) begin
                pv[i] = longint'((128'(ad[i]) * ov) / root);
                if (dv[i] < 0) pv[i] = -pv[i];
            end
        end
        for (int i = 0; i < 3; i++) begin
            if (pv[i] > 64'sd2147483647) pv[i] = 64'sd2147483647;
            if (pv[i] < -64'sd2147483648) pv[i] = -64'sd2147483648;
        end
        r.push_x      = 32'(pv[0]);
        r.push_y      = 32'(pv[1]);
        r.push_z      = 32'(pv[2]);
        r.penetrating = (pv[0] != 0 || pv[1] != 0 || pv[2] != 0);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (push_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result x=%0d y=%0d z=%0d pen=%0b",
                             o_data.push_x, o_data.push_y, o_data.push_z,
                             o_data.penetrating);
            end else begin
                want = push_q.pop_front();
                if (want.push_x != o_data.push_x || want.push_y != o_data.push_y ||
                    want.push_z != o_data.push_z ||
                    want.penetrating != o_data.penetrating) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp x=%0d y=%0d z=%0d pen=%0b, got x=%0d y=%0d z=%0d pen=%0b",
                                 want.push_x, want.push_y, want.push_z, want.penetrating,
                                 o_data.push_x, o_data.push_y, o_data.push_z,
                                 o_data.penetrating);
                end
            end
        end
    end

    function automatic t_in mk_query(longint bx, longint by, longint bz,
                                     longint sx, longint sy, longint sz,
                                     longint px, longint py, longint pz,
                                     longint rad);
        t_in q;
        q.box_x = 32'(bx); q.box_y = 32'(by); q.box_z = 32'(bz);
        q.box_size_x = 31'(sx); q.box_size_y = 31'(sy); q.box_size_z = 31'(sz);
        q.sphere_x = 32'(px); q.sphere_y = 32'(py); q.sphere_z = 32'(pz);
        q.sphere_radius = 31'(rad);
        return q;
    endfunction

    function automatic t_out mk_push(longint x, longint y, longint z, bit pen);
        t_out r;
        r.push_x = 32'(x); r.push_y = 32'(y); r.push_z = 32'(z); r.penetrating = pen;
        return r;
    endfunction

    // sender burst state
    int burst_left = 0;

    task automatic send_query(t_in q, bit typed, t_out typed_push);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        i_valid <= 1'b1;
        i_data  <= q;
        do @(posedge i_clk); while (o_stall);
        push_q.push_back(typed ? typed_push : predict_push(q, eps_now));
        burst_left--;
    endtask

    task automatic settle_and_write(logic [EPS_W-1:0] val);
        i_valid <= 1'b0;
        burst_left = 0;
        while (push_q.size() != 0) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        eps_now = val;
    endtask

    function automatic longint rnd_signed(int span);
        return longint'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic t_in rnd_query();
        t_in    q;
        longint sz[3], c[3], p[3], rad;
        int     kind;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            // raw noise across every bit
            q = $bits(t_in)'({$urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom, $urandom, $urandom});
            return q;
        end
        for (int i = 0; i < 3; i++) begin
            c[i]  = (kind == 1) ? longint'($signed($urandom)) : rnd_signed(1 << 22);
            sz[i] = (kind == 1) ? longint'($urandom & 32'h7fff_ffff)
                                : longint'($urandom_range(0, 1 << 21));
        end
        rad = (kind == 1) ? longint'($urandom & 32'h7fff_ffff)
                          : longint'($urandom_range(0, 1 << 20));
        for (int i = 0; i < 3; i++) begin
            if (kind == 2)       // near the centre: degenerate push
                p[i] = c[i] + ((i == 0) ? rnd_signed(2 * ONE) : rnd_signed(8));
            else if (kind == 3)  // on or just past the high face on every axis
                p[i] = c[i] + (sz[i] >> 1) + $urandom_range(0, 70000);
            else
                p[i] = c[i] + rnd_signed(int'((sz[i] >> 1) + rad + 1024));
        end
        return mk_query(c[0], c[1], c[2], sz[0], sz[1], sz[2], p[0], p[1], p[2], rad);
    endfunction

    t_row directed[$];
    logic [EPS_W-1:0] eps_plan[N_PHASE] = '{EPS_RESET, 16'd0, 16'hffff, 16'd0, 16'd1};

    initial begin
        directed.push_back('{mk_query(0, 0, 0, 2*ONE, 2*ONE, 2*ONE, 0, 0, 0, ONE),
                             1'b1, mk_push(0, 0, 0, 0)});
        directed.push_back('{mk_query(0, 0, 0, 2*ONE, 2*ONE, 2*ONE, 10*ONE, 0, 0, ONE),
                             1'b1, mk_push(0, 0, 0, 0)});
        directed.push_back('{mk_query(0, 0, 0, 20*ONE, 20*ONE, 20*ONE, 5*ONE, 0, 0, ONE),
                             1'b1, mk_push(ONE, 0, 0, 1)});
        directed.push_back('{mk_query(0, 0, 0, 20*ONE, 20*ONE, 20*ONE, -5*ONE, 0, 0, ONE),
                             1'b1, mk_push(-ONE, 0, 0, 1)});
        directed.push_back('{mk_query(0, 0, 0, 20*ONE, 20*ONE, 20*ONE, 3, 0, 0, ONE),
                             1'b1, mk_push(3, 0, 0, 1)});
        directed.push_back('{mk_query(0, 0, 0, 4*ONE, 4*ONE, 4*ONE, 2*ONE + ONE/2, 0, 0, ONE),
                             1'b1, mk_push(ONE/2, 0, 0, 1)});
        directed.push_back('{mk_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                             1'b1, mk_push(0, 0, 0, 0)});
        directed.push_back('{mk_query(2147483647, 2147483647, 2147483647,
                                      2147483647, 2147483647, 2147483647,
                                      -2147483648, -2147483648, -2147483648, 2147483647),
                             1'b0, '0});
        directed.push_back('{mk_query(-2147483648, -2147483648, -2147483648, 0, 0, 0,
                                      2147483647, 2147483647, 2147483647, 2147483647),
                             1'b0, '0});
        directed.push_back('{mk_query(2147483647, 2147483647, 2147483647,
                                      2147483647, 2147483647, 2147483647,
                                      2147483647, 2147483647, 2147483647, 2147483647),
                             1'b0, '0});
        directed.push_back('{mk_query(0, 0, 0, 2*ONE, 2*ONE, 2*ONE, ONE+ONE/2, -ONE-ONE/2,
                                      ONE+ONE/4, ONE), 1'b0, '0});
        directed.push_back('{mk_query(0, 0, 0, 2*ONE, 2*ONE, 2*ONE, 0, -ONE-4, -ONE-3, ONE),
                             1'b0, '0});
        directed.push_back('{mk_query(0, 0, 0, 2*ONE, 2*ONE, 2*ONE, 2*ONE, 0, 0, 0),
                             1'b0, '0});
        directed.push_back('{mk_query(-ONE, ONE, 0, 0, 2*ONE, 0, -ONE-100, ONE, 5, 300),
                             1'b0, '0});

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k])
            send_query(directed[k].query, directed[k].typed, directed[k].push);

        for (int ph = 0; ph < N_PHASE; ph++) begin
            if (ph == 3) eps_plan[ph] = 16'($urandom_range(2, 65534));
            settle_and_write(eps_plan[ph]);
            for (int k = 0; k < N_RAND; k++)
                send_query(rnd_query(), 1'b0, '0);
        end

        i_valid <= 1'b0;
        while (push_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (mismatches == 0 && push_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
